FILE: rtl/ws_dfr_pkg.sv
// ----------------------------------------------------------------------------
// ws_dfr_pkg: shared types and constants of the WebSocket frame deframer
// Parse phases, event codes, header constants and the result beat type.
// ----------------------------------------------------------------------------
package ws_dfr_pkg;

   localparam int LEN_W = 63;

   typedef enum logic [2:0] {
      PH_HDR0  = 3'd0,
      PH_HDR1  = 3'd1,
      PH_EXT16 = 3'd2,
      PH_EXT64 = 3'd3,
      PH_KEY   = 3'd4,
      PH_DATA  = 3'd5
   } phase_type;

   localparam logic [1:0] EV_HEADER    = 2'd0;
   localparam logic [1:0] EV_PAYLOAD   = 2'd1;
   localparam logic [1:0] EV_TOO_LARGE = 2'd2;
   localparam logic [1:0] EV_BAD_OP    = 2'd3;

   localparam logic [6:0] LEN16_CODE = 7'd126;
   localparam logic [6:0] LEN64_CODE = 7'd127;

   localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = LEN_W'(4 * 1048576);

   localparam logic [2:0] EXT16_LAST = 3'd1;
   localparam logic [2:0] EXT64_LAST = 3'd7;
   localparam logic [2:0] KEY_LAST   = 3'd3;

   typedef struct packed {
      logic [1:0]       event_kind;
      logic             fin_flag;
      logic [2:0]       reserved_bits;
      logic [3:0]       frame_opcode;
      logic             was_masked;
      logic [LEN_W-1:0] payload_length;
      logic [7:0]       payload_byte;
      logic             last_byte;
   } rsp_beat_type;

endpackage

FILE: rtl/ws_dfr_if.sv
// ----------------------------------------------------------------------------
// ws_dfr_if: valid/ready channels of the WebSocket frame deframer
// One interface for the received byte stream and one for the result stream.
// ----------------------------------------------------------------------------
interface ws_dfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface ws_dfr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_kind;
   logic        fin_flag;
   logic [2:0]  reserved_bits;
   logic [3:0]  frame_opcode;
   logic        was_masked;
   logic [62:0] payload_length;
   logic [7:0]  payload_byte;
   logic        last_byte;

   modport source (output valid, output event_kind, output fin_flag, output reserved_bits,
                   output frame_opcode, output was_masked, output payload_length,
                   output payload_byte, output last_byte, input ready);
   modport sink (input valid, input event_kind, input fin_flag, input reserved_bits,
                 input frame_opcode, input was_masked, input payload_length,
                 input payload_byte, input last_byte, output ready);
endinterface

FILE: rtl/ws_dfr_in_reg.sv
// ----------------------------------------------------------------------------
// ws_dfr_in_reg: input byte register
// Captures one received byte and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module ws_dfr_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   output logic       out_valid,
   output logic [7:0] out_byte,
   input  logic       out_take
);
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       load;

   assign in_ready = !valid_ff || out_take;
   assign load     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = in_byte;
      end else if (out_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
endmodule

FILE: rtl/ws_dfr_parser.sv
// ----------------------------------------------------------------------------
// ws_dfr_parser: frame header parser and payload unmasker
// Consumes one byte per take, updates the parse state, may form a result beat.
// ----------------------------------------------------------------------------
module ws_dfr_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [62:0]              csr_wr_data,
   input  logic                     take,
   input  logic [7:0]               rx_byte,
   output logic                     res_valid,
   output ws_dfr_pkg::rsp_beat_type res_beat
);
   import ws_dfr_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic [63:0]      length_ff, length_in;
   logic [31:0]      key_ff, key_in;
   logic             mask_on_ff, mask_on_in;
   logic [LEN_W-1:0] remaining_ff, remaining_in;
   logic [1:0]       key_pos_ff, key_pos_in;
   logic [7:0]       header_ff, header_in;
   logic             drop_ff, drop_in;
   logic             halted_ff, halted_in;
   logic [LEN_W-1:0] max_payload_ff;

   logic [6:0]       len7;
   logic [63:0]      acc16, acc64;
   logic             oversize, finish, bad_op, target_empty, last;
   logic [LEN_W-1:0] remaining_dec;
   logic [7:0]       key_byte;
   phase_type        finish_phase;

   assign len7          = rx_byte[6:0];
   assign acc16         = {48'd0, length_ff[7:0], rx_byte};
   assign acc64         = {length_ff[55:0], rx_byte};
   assign oversize      = acc64 > {1'b0, max_payload_ff};
   assign bad_op        = (header_ff[3:0] > 4'd2 && header_ff[3:0] < 4'd8) ||
                          header_ff[3:0] > 4'd10;
   assign remaining_dec = (remaining_ff != '0) ? remaining_ff - LEN_W'(1) : remaining_ff;
   assign last          = (remaining_dec == '0);
   assign target_empty  = (length_in[LEN_W-1:0] == '0);
   assign finish_phase  = target_empty ? PH_HDR0 : PH_DATA;

   always_comb begin
      case (key_pos_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
      if (!mask_on_ff) begin
         key_byte = 8'd0;
      end
   end

   // Header ends on the last header, in-range unmasked length or key byte.
   always_comb begin
      finish = 1'b0;
      unique case (phase_ff)
         PH_HDR1:  finish = len7 != LEN16_CODE && len7 != LEN64_CODE && !rx_byte[7];
         PH_EXT16: finish = cnt_ff == EXT16_LAST && !mask_on_ff;
         PH_EXT64: finish = cnt_ff == EXT64_LAST && !oversize && !mask_on_ff;
         PH_KEY:   finish = cnt_ff == KEY_LAST;
         default:  finish = 1'b0;
      endcase
   end

   // Next parse phase.
   always_comb begin
      phase_in = phase_ff;
      if (take && !halted_ff) begin
         unique case (phase_ff)
            PH_HDR0: phase_in = PH_HDR1;
            PH_HDR1: begin
               if (len7 == LEN16_CODE) begin
                  phase_in = PH_EXT16;
               end else if (len7 == LEN64_CODE) begin
                  phase_in = PH_EXT64;
               end else if (rx_byte[7]) begin
                  phase_in = PH_KEY;
               end else begin
                  phase_in = finish_phase;
               end
            end
            PH_EXT16: begin
               if (cnt_ff == EXT16_LAST) begin
                  phase_in = mask_on_ff ? PH_KEY : finish_phase;
               end
            end
            PH_EXT64: begin
               if (cnt_ff == EXT64_LAST && !oversize) begin
                  phase_in = mask_on_ff ? PH_KEY : finish_phase;
               end
            end
            PH_KEY: begin
               if (cnt_ff == KEY_LAST) begin
                  phase_in = finish_phase;
               end
            end
            PH_DATA: begin
               if (last) begin
                  phase_in = PH_HDR0;
               end
            end
            default: phase_in = PH_HDR0;
         endcase
      end
   end

   // Datapath state and result beat.
   always_comb begin
      cnt_in       = cnt_ff;
      length_in    = length_ff;
      key_in       = key_ff;
      mask_on_in   = mask_on_ff;
      remaining_in = remaining_ff;
      key_pos_in   = key_pos_ff;
      header_in    = header_ff;
      drop_in      = drop_ff;
      halted_in    = halted_ff;
      res_valid    = 1'b0;
      res_beat     = '0;
      if (take && !halted_ff) begin
         unique case (phase_ff)
            PH_HDR0: header_in = rx_byte;
            PH_HDR1: begin
               mask_on_in = rx_byte[7];
               key_in     = '0;
               cnt_in     = '0;
               length_in  = (len7 == LEN16_CODE || len7 == LEN64_CODE) ? 64'd0
                                                                       : {57'd0, len7};
            end
            PH_EXT16: begin
               length_in = acc16;
               cnt_in    = (cnt_ff == EXT16_LAST) ? 3'd0 : 3'(cnt_ff + 3'd1);
            end
            PH_EXT64: begin
               length_in = acc64;
               cnt_in    = (cnt_ff == EXT64_LAST) ? 3'd0 : 3'(cnt_ff + 3'd1);
               if (cnt_ff == EXT64_LAST && oversize) begin
                  halted_in           = 1'b1;
                  res_valid           = 1'b1;
                  res_beat.event_kind = EV_TOO_LARGE;
               end
            end
            PH_KEY: begin
               key_in = {key_ff[23:0], rx_byte};
               cnt_in = (cnt_ff == KEY_LAST) ? 3'd0 : 3'(cnt_ff + 3'd1);
            end
            PH_DATA: begin
               key_pos_in   = 2'(key_pos_ff + 2'd1);
               remaining_in = remaining_dec;
               if (drop_ff) begin
                  if (last) begin
                     drop_in = 1'b0;
                  end
               end else begin
                  res_valid             = 1'b1;
                  res_beat.event_kind   = EV_PAYLOAD;
                  res_beat.payload_byte = rx_byte ^ key_byte;
                  res_beat.last_byte    = last;
               end
            end
            default: ;
         endcase
         if (finish) begin
            drop_in             = bad_op;
            remaining_in        = length_in[LEN_W-1:0];
            key_pos_in          = '0;
            res_valid           = 1'b1;
            res_beat.event_kind = bad_op ? EV_BAD_OP : EV_HEADER;
         end
         res_beat.fin_flag       = header_in[7];
         res_beat.reserved_bits  = header_in[6:4];
         res_beat.frame_opcode   = header_in[3:0];
         res_beat.was_masked     = mask_on_in;
         res_beat.payload_length = length_in[LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HDR0;
         cnt_ff         <= '0;
         length_ff      <= '0;
         key_ff         <= '0;
         mask_on_ff     <= 1'b0;
         remaining_ff   <= '0;
         key_pos_ff     <= '0;
         header_ff      <= '0;
         drop_ff        <= 1'b0;
         halted_ff      <= 1'b0;
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else begin
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         length_ff    <= length_in;
         key_ff       <= key_in;
         mask_on_ff   <= mask_on_in;
         remaining_ff <= remaining_in;
         key_pos_ff   <= key_pos_in;
         header_ff    <= header_in;
         drop_ff      <= drop_in;
         halted_ff    <= halted_in;
         if (csr_wr_en) begin
            max_payload_ff <= csr_wr_data;
         end
      end
   end
endmodule

FILE: rtl/ws_dfr_out_buf.sv
// ----------------------------------------------------------------------------
// ws_dfr_out_buf: two-entry result buffer
// Holds beats so the parser runs on during a sink stall, until both are full.
// ----------------------------------------------------------------------------
module ws_dfr_out_buf (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_valid,
   input  ws_dfr_pkg::rsp_beat_type wr_beat,
   output logic                     has_space,
   output logic                     rd_valid,
   output ws_dfr_pkg::rsp_beat_type rd_beat,
   input  logic                     rd_ready
);
   import ws_dfr_pkg::*;

   rsp_beat_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push, pop;

   assign has_space = (count_ff != 2'd2);
   assign rd_valid  = (count_ff != 2'd0);
   assign rd_beat   = slot_ff[rd_ptr_ff];
   assign push      = wr_valid && has_space;
   assign pop       = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = 2'(count_ff + 2'd1);
      end else if (pop && !push) begin
         count_in = 2'(count_ff - 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_beat;
      end
   end
endmodule

FILE: rtl/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer: receive-side WebSocket frame parser
// Parses frame headers from a byte stream and delivers unmasked payload bytes.
// ----------------------------------------------------------------------------
// The deframer takes one received byte per clock cycle on req_if while its
// output buffer has room, and gives at most one result beat per byte on
// rsp_if: each byte is held in the input register, then goes through the
// header parser and unmasker, whose result lands in a two-entry output buffer.
// With rsp_if.ready held high the sustained rate is one byte every cycle; it
// is set by the single parser stage, which updates its whole state from each
// byte. Header bytes give no beat until the header is complete, which yields a
// header beat (event 0) or a bad-opcode beat (event 3). Payload bytes of a
// good frame come out as payload beats (event 1), with last_byte marking the
// final byte; payload bytes of a bad-opcode frame are dropped. A 64-bit length
// above max_payload gives a frame-too-large beat (event 2) and the block then
// swallows all further bytes until reset. The user writes max_payload through
// csr_wr_en and csr_wr_data only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
   input  logic         clock,
   input  logic         reset,
   ws_dfr_req_if.sink   req_if,
   ws_dfr_rsp_if.source rsp_if,
   input  logic         csr_wr_en,
   input  logic [62:0]  csr_wr_data
);
   import ws_dfr_pkg::*;

   logic         byte_valid;
   logic [7:0]   byte_data;
   logic         take;
   logic         res_valid;
   rsp_beat_type res_beat;
   logic         has_space;
   rsp_beat_type out_beat;

   // The parser takes the registered byte whenever the output buffer can
   // absorb a possible result beat.
   assign take = byte_valid && has_space;

   ws_dfr_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .in_byte   (req_if.rx_byte),
      .out_valid (byte_valid),
      .out_byte  (byte_data),
      .out_take  (take)
   );

   ws_dfr_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .take        (take),
      .rx_byte     (byte_data),
      .res_valid   (res_valid),
      .res_beat    (res_beat)
   );

   ws_dfr_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .wr_valid  (res_valid),
      .wr_beat   (res_beat),
      .has_space (has_space),
      .rd_valid  (rsp_if.valid),
      .rd_beat   (out_beat),
      .rd_ready  (rsp_if.ready)
   );

   // Result beat fields onto the channel.
   assign rsp_if.event_kind     = out_beat.event_kind;
   assign rsp_if.fin_flag       = out_beat.fin_flag;
   assign rsp_if.reserved_bits  = out_beat.reserved_bits;
   assign rsp_if.frame_opcode   = out_beat.frame_opcode;
   assign rsp_if.was_masked     = out_beat.was_masked;
   assign rsp_if.payload_length = out_beat.payload_length;
   assign rsp_if.payload_byte   = out_beat.payload_byte;
   assign rsp_if.last_byte      = out_beat.last_byte;
endmodule
